>>> src/chs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chs_pkg
// Shared constants and types of the chained hash key-value store.
// ----------------------------------------------------------------------------
package chs_pkg;

  localparam int Buckets    = 16;
  localparam int MaxEntries = 64;
  localparam int BW = $clog2(Buckets);
  localparam int EW = $clog2(MaxEntries);
  localparam int CW = $clog2(MaxEntries + 1);

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

endpackage
`default_nettype wire

>>> src/chained_hash_key_value_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_key_value_store
// Hash table of 32-bit keys and values, separate chaining over an entry pool.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (command, key, value) arrive on a valid/ready channel; each
//   gives one result word (value_out, found, refused, entry_total, is_empty)
//   on a second valid/ready channel, held in an output register.
//   A command first reads the bucket head (S_HEAD), then walks the chain
//   entry by entry, each with a memory read (S_RD) and then a compare
//   (S_CMP). Table writes are made in the compare cycle of a hit or in the
//   last read cycle of a miss. The result is then registered from S_DONE
//   once the output register is free, and the next word is accepted back
//   in S_IDLE. Clear skips the head read and the walk and goes straight
//   to S_DONE.
//   A free entry is found by a priority search over the in-use flags, held
//   in flip-flops, as are the bucket head valid bits; reset clears them at
//   once, so no clearing pass is needed. Stored keys, values and links lie
//   in a synchronous memory with a registered read.
//   If the receiver stalls, the result waits and at most one further
//   command is processed up to its result before the block waits too.
// ----------------------------------------------------------------------------
module chained_hash_key_value_store
  import chs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        valid,
  output logic             ready,
  input  wire logic [1:0]  command,
  input  wire logic [31:0] key,
  input  wire logic [31:0] value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      value_out,
  output logic             found,
  output logic             refused,
  output logic [6:0]       entry_total,
  output logic             is_empty
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_HEAD  = 6'b000010,
    S_RD    = 6'b000100,
    S_CMP   = 6'b001000,
    S_DONE  = 6'b010000,
    S_WAIT  = 6'b100000
  } state_t;

  // entry memory word: key, value, link
  logic [31:0] ekey_mem [MaxEntries];
  logic [31:0] eval_mem [MaxEntries];
  logic [EW:0] elink_mem [MaxEntries];    // msb = link valid
  logic [EW:0] head_mem [Buckets];        // msb unused, valid in head_ok

  logic [Buckets-1:0]    head_ok;
  logic [MaxEntries-1:0] in_use;
  logic [CW-1:0]         count;

  state_t      state;
  cmd_t        cmd;
  logic [31:0] key_r, val_r;
  logic [BW-1:0] bkt;
  logic [EW-1:0] cur, prev;
  logic        has_prev, cur_ok;
  logic [EW:0] steps;

  // result held here until the output register is free
  logic [31:0] res_value;
  logic        res_found, res_refused;

  logic [EW-1:0] rd_addr;
  logic [31:0]   rd_key, rd_val;
  logic [EW:0]   rd_link;
  logic [EW:0]   hd_q;

  // lowest free entry
  logic [EW-1:0] free_idx;
  logic          free_ok;
  always_comb begin
    free_idx = '0;
    free_ok  = 1'b0;
    for (int i = MaxEntries - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_idx = EW'(i);
        free_ok  = 1'b1;
      end
    end
  end

  assign ready = (state == S_IDLE);
  // first read of a chain must address the head entry
  assign rd_addr = (state == S_RD && !has_prev) ? hd_q[EW-1:0] : cur;

  always_ff @(posedge clk) begin
    rd_key  <= ekey_mem[rd_addr];
    rd_val  <= eval_mem[rd_addr];
    rd_link <= elink_mem[rd_addr];
    hd_q    <= head_mem[bkt];
  end

  logic hit;
  assign hit = (rd_key == key_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head_ok   <= '0;
      in_use    <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (valid) begin
            cmd      <= cmd_t'(command);
            key_r    <= key;
            val_r    <= value;
            bkt      <= key[BW-1:0];
            has_prev <= 1'b0;
            prev     <= '0;
            steps    <= '0;
            if (cmd_t'(command) == CMD_CLEAR) begin
              head_ok     <= '0;
              in_use      <= '0;
              count       <= '0;
              res_value   <= '0;
              res_found   <= 1'b0;
              res_refused <= 1'b0;
              state       <= S_DONE;
            end else begin
              state <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          // head read lands next cycle
          state <= S_RD;
          cur_ok <= head_ok[bkt];
        end
        S_RD: begin
          if (!has_prev) cur <= hd_q[EW-1:0];
          if (!cur_ok || steps == (EW+1)'(MaxEntries)) begin
            // miss: chain end or step limit reached
            res_found   <= 1'b0;
            res_value   <= '0;
            res_refused <= 1'b0;
            if (cmd == CMD_PUT) begin
              if (!free_ok) begin
                res_refused <= 1'b1;
              end else begin
                ekey_mem[free_idx]  <= key_r;
                eval_mem[free_idx]  <= val_r;
                elink_mem[free_idx] <= '0;
                in_use[free_idx]    <= 1'b1;
                count               <= count + CW'(1);
                if (has_prev) elink_mem[prev] <= {1'b1, free_idx};
                else begin
                  head_mem[bkt] <= {1'b0, free_idx};
                  head_ok[bkt]  <= 1'b1;
                end
              end
            end
            state <= S_DONE;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (hit) begin
            res_found   <= 1'b1;
            res_refused <= 1'b0;
            res_value   <= rd_val;
            if (cmd == CMD_PUT) eval_mem[cur] <= val_r;
            if (cmd == CMD_REMOVE) begin
              if (has_prev) elink_mem[prev] <= rd_link;
              else begin
                head_mem[bkt] <= {1'b0, rd_link[EW-1:0]};
                head_ok[bkt]  <= rd_link[EW];
              end
              in_use[cur] <= 1'b0;
              if (count != '0) count <= count - CW'(1);
            end
            state <= S_DONE;
          end else begin
            prev     <= cur;
            has_prev <= 1'b1;
            cur      <= rd_link[EW-1:0];
            cur_ok   <= rd_link[EW];
            steps    <= steps + (EW+1)'(1);
            state    <= S_RD;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            value_out   <= res_value;
            found       <= res_found;
            refused     <= res_refused;
            entry_total <= 7'(count);
            is_empty    <= (count == '0);
            state       <= S_IDLE;
          end
        end
        S_WAIT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (count == CW'($countones(in_use))))
    else $error("entry count out of step with in-use flags");
  assert property (@(posedge clk) disable iff (rst)
    (count <= CW'(MaxEntries)))
    else $error("entry count beyond pool size");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && refused |-> !found)
    else $error("refused result reports a hit");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (cmd != CMD_CLEAR))
    else $error("clear entered chain walk");

endmodule
`default_nettype wire
